### hdl/lsbs_pkg.sv
// ----------------------------------------------------------------------------
// lsbs_pkg
// shared widths, constants, register indexes and control structs for the
// laser scan steering block
// ----------------------------------------------------------------------------
`default_nettype none

package lsbs_pkg;

    localparam int MaxBeams = 4096;
    localparam int BeamW    = 12;
    localparam int CountW   = 13;
    localparam int RangeW   = 16;
    localparam int CfgW     = 16;
    localparam int CfgAddrW = 2;
    localparam int ProdW    = 32;
    localparam int NumW     = 42;
    localparam int DivW     = 34;
    localparam int DivCntW  = 6;
    localparam int AngW     = 28;
    localparam int MagW     = 32;
    localparam int ScaledW  = 38;
    localparam int TurnW    = 32;
    localparam int SpeedW   = 16;

    localparam logic [RangeW-1:0] MinValidRange = 16'd50;
    localparam logic [RangeW-1:0] CloseRange    = 16'd250;
    localparam logic [AngW-1:0]   CloseAngle    = 28'd700000;
    localparam logic [NumW-1:0]   MradScale     = 42'd1000;
    localparam logic [ScaledW-1:0] CloseBoost   = 38'd50;
    localparam logic [MagW-1:0]   MagLimit      = 32'h8000_0000;
    localparam logic [TurnW-1:0]  TurnPosMax    = 32'h7FFF_FFFF;

    localparam logic [CfgAddrW-1:0] CFG_ANGLE_COEF  = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_ROBOT_SPEED = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_BEAM_COUNT  = 2'd2;
    localparam logic [CfgAddrW-1:0] CFG_ANGLE_STEP  = 2'd3;

    typedef struct packed {
        logic beam_en;
        logic mul1;
        logic mul2;
        logic div_step;
        logic fin_load;
    } lsbs_cmd_t;

    typedef struct packed {
        logic last_beam;
        logic div_done;
    } lsbs_stat_t;

endpackage

`default_nettype wire

### hdl/lsbs_ctrl.sv
// ----------------------------------------------------------------------------
// lsbs_ctrl
// sequencer: beam intake, end-of-scan multiply, divide and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module lsbs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output      logic               s_tready,
    output      logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire lsbs_pkg::lsbs_stat_t stat,
    output      lsbs_pkg::lsbs_cmd_t  cmd
);

    localparam logic [2:0] S_RUN  = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign s_tready = (state_reg == S_RUN);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_RUN:
            begin
                cmd.beam_en = accept;
                if (accept && stat.last_beam)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.fin_load = 1'b1;
                    state_next   = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hdl/lsbs_dpath.sv
// ----------------------------------------------------------------------------
// lsbs_dpath
// config registers, per-half minimum tracking, gain multiply, restoring
// divider and output saturation
// ----------------------------------------------------------------------------
`default_nettype none

module lsbs_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lsbs_pkg::CfgAddrW-1:0]     cfg_addr,
    input  wire logic [lsbs_pkg::CfgW-1:0]         cfg_wdata,
    input  wire logic [lsbs_pkg::RangeW-1:0]       range_mm,
    input  wire lsbs_pkg::lsbs_cmd_t               cmd,
    output      lsbs_pkg::lsbs_stat_t              stat,
    output      logic [lsbs_pkg::TurnW-1:0]        turn_rate,
    output      logic [lsbs_pkg::SpeedW-1:0]       forward_speed
);

    logic [lsbs_pkg::CfgW-1:0]    angle_coef_reg;
    logic [lsbs_pkg::CfgW-1:0]    robot_speed_reg;
    logic [lsbs_pkg::CountW-1:0]  beam_count_reg;
    logic [lsbs_pkg::CfgW-1:0]    angle_step_reg;

    logic [lsbs_pkg::BeamW-1:0]   beam_index_reg;
    logic [lsbs_pkg::RangeW-1:0]  right_min_range_reg;
    logic [lsbs_pkg::BeamW-1:0]   right_min_beam_reg;
    logic [lsbs_pkg::RangeW-1:0]  left_min_range_reg;
    logic [lsbs_pkg::BeamW-1:0]   left_min_beam_reg;

    logic [lsbs_pkg::ProdW-1:0]   prod_reg;
    logic [lsbs_pkg::AngW-1:0]    ang_l_reg;
    logic [lsbs_pkg::AngW-1:0]    ang_r_reg;
    logic                         l_before_reg;
    logic                         r_before_reg;
    logic                         close_reg;
    logic                         num_zero_reg;
    logic [lsbs_pkg::DivW-1:0]    div_num_reg;
    logic [lsbs_pkg::RangeW-1:0]  div_rem_reg;
    logic [lsbs_pkg::DivCntW-1:0] div_cnt_reg;
    logic [lsbs_pkg::TurnW-1:0]   turn_reg;
    logic [lsbs_pkg::SpeedW-1:0]  speed_reg;

    logic [lsbs_pkg::CountW-1:0]  eff_count;
    logic [lsbs_pkg::BeamW-1:0]   half;
    logic [lsbs_pkg::CountW-1:0]  beam_ext;
    logic                         pos;
    logic [lsbs_pkg::RangeW-1:0]  big;
    logic [lsbs_pkg::RangeW-1:0]  small_val;
    logic [lsbs_pkg::BeamW-1:0]   l_off;
    logic [lsbs_pkg::BeamW-1:0]   r_off;
    logic [lsbs_pkg::NumW-1:0]    num_full;
    logic [lsbs_pkg::RangeW:0]    rem_sh;
    logic [lsbs_pkg::RangeW:0]    rem_sub;
    logic                         rem_ge;
    logic [lsbs_pkg::MagW-1:0]    mag;
    logic [lsbs_pkg::ScaledW-1:0] scaled;
    logic [lsbs_pkg::ScaledW-1:0] neg_lim;
    logic [lsbs_pkg::TurnW-1:0]   turn_val;

    // clamp beam count into 2 .. max beams
    always_comb
    begin
        eff_count = beam_count_reg;
        if (beam_count_reg < lsbs_pkg::CountW'(2))
        begin
            eff_count = lsbs_pkg::CountW'(2);
        end
        else if (beam_count_reg > lsbs_pkg::CountW'(lsbs_pkg::MaxBeams))
        begin
            eff_count = lsbs_pkg::CountW'(lsbs_pkg::MaxBeams);
        end
    end

    assign half     = eff_count[lsbs_pkg::CountW-1:1];
    assign beam_ext = {1'b0, beam_index_reg};

    assign stat.last_beam = (beam_ext >= (eff_count - lsbs_pkg::CountW'(1)));
    assign stat.div_done  = (div_cnt_reg == lsbs_pkg::DivCntW'(lsbs_pkg::DivW - 1));

    assign pos       = (left_min_range_reg >= right_min_range_reg);
    assign big       = pos ? left_min_range_reg : right_min_range_reg;
    assign small_val = pos ? right_min_range_reg : left_min_range_reg;
    assign l_off     = left_min_beam_reg - half;
    assign r_off     = right_min_beam_reg - half;
    assign num_full  = lsbs_pkg::NumW'(prod_reg) * lsbs_pkg::MradScale;

    // restoring divide step
    assign rem_sh  = {div_rem_reg, div_num_reg[lsbs_pkg::DivW-1]};
    assign rem_ge  = (rem_sh >= {1'b0, small_val});
    assign rem_sub = rem_sh - {1'b0, small_val};

    always_comb
    begin
        if (num_zero_reg)
        begin
            mag = '0;
        end
        else if ((small_val == '0) ||
                 (div_num_reg > lsbs_pkg::DivW'(lsbs_pkg::MagLimit)))
        begin
            mag = lsbs_pkg::MagLimit;
        end
        else
        begin
            mag = div_num_reg[lsbs_pkg::MagW-1:0];
        end
    end

    assign scaled = close_reg ? (lsbs_pkg::ScaledW'(mag) * lsbs_pkg::CloseBoost)
                              : lsbs_pkg::ScaledW'(mag);

    always_comb
    begin
        neg_lim = scaled;
        if (scaled > lsbs_pkg::ScaledW'(lsbs_pkg::MagLimit))
        begin
            neg_lim = lsbs_pkg::ScaledW'(lsbs_pkg::MagLimit);
        end
        if (pos)
        begin
            if (scaled > lsbs_pkg::ScaledW'(lsbs_pkg::TurnPosMax))
            begin
                turn_val = lsbs_pkg::TurnPosMax;
            end
            else
            begin
                turn_val = scaled[lsbs_pkg::TurnW-1:0];
            end
        end
        else
        begin
            turn_val = lsbs_pkg::TurnW'(0) - neg_lim[lsbs_pkg::TurnW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_coef_reg      <= 16'd512;
            robot_speed_reg     <= 16'd300;
            beam_count_reg      <= 13'd720;
            angle_step_reg      <= 16'd6136;
            beam_index_reg      <= '0;
            right_min_range_reg <= '0;
            right_min_beam_reg  <= '0;
            left_min_range_reg  <= '0;
            left_min_beam_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    lsbs_pkg::CFG_ANGLE_COEF:  angle_coef_reg  <= cfg_wdata;
                    lsbs_pkg::CFG_ROBOT_SPEED: robot_speed_reg <= cfg_wdata;
                    lsbs_pkg::CFG_BEAM_COUNT:
                        beam_count_reg <= cfg_wdata[lsbs_pkg::CountW-1:0];
                    lsbs_pkg::CFG_ANGLE_STEP:  angle_step_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.beam_en)
            begin
                if (beam_index_reg < half)
                begin
                    if (beam_index_reg == '0)
                    begin
                        right_min_range_reg <= range_mm;
                        right_min_beam_reg  <= '0;
                    end
                    else if ((range_mm < right_min_range_reg) &&
                             (range_mm > lsbs_pkg::MinValidRange))
                    begin
                        right_min_range_reg <= range_mm;
                        right_min_beam_reg  <= beam_index_reg;
                    end
                end
                else
                begin
                    if ((beam_index_reg == half) ||
                        ((range_mm < left_min_range_reg) &&
                         (range_mm > lsbs_pkg::MinValidRange)))
                    begin
                        left_min_range_reg <= range_mm;
                        left_min_beam_reg  <= beam_index_reg;
                    end
                end
                if (stat.last_beam)
                begin
                    beam_index_reg <= '0;
                end
                else
                begin
                    beam_index_reg <= beam_index_reg + lsbs_pkg::BeamW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            prod_reg     <= lsbs_pkg::ProdW'(angle_coef_reg) *
                            lsbs_pkg::ProdW'(big - small_val);
            ang_l_reg    <= lsbs_pkg::AngW'(l_off) * lsbs_pkg::AngW'(angle_step_reg);
            ang_r_reg    <= lsbs_pkg::AngW'(r_off) * lsbs_pkg::AngW'(angle_step_reg);
            l_before_reg <= (left_min_beam_reg < half);
            r_before_reg <= (right_min_beam_reg < half);
        end
        if (cmd.mul2)
        begin
            div_num_reg  <= num_full[lsbs_pkg::NumW-1:lsbs_pkg::NumW-lsbs_pkg::DivW];
            num_zero_reg <= (prod_reg == '0);
            div_rem_reg  <= '0;
            div_cnt_reg  <= '0;
            close_reg    <= (left_min_range_reg < lsbs_pkg::CloseRange) &&
                            (right_min_range_reg < lsbs_pkg::CloseRange) &&
                            (l_before_reg || (ang_l_reg < lsbs_pkg::CloseAngle)) &&
                            (r_before_reg || (ang_r_reg < lsbs_pkg::CloseAngle));
        end
        if (cmd.div_step)
        begin
            div_rem_reg <= rem_ge ? rem_sub[lsbs_pkg::RangeW-1:0]
                                  : rem_sh[lsbs_pkg::RangeW-1:0];
            div_num_reg <= {div_num_reg[lsbs_pkg::DivW-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + lsbs_pkg::DivCntW'(1);
        end
        if (cmd.fin_load)
        begin
            turn_reg  <= turn_val;
            speed_reg <= close_reg ? (robot_speed_reg >> 1) : robot_speed_reg;
        end
    end

    assign turn_rate     = turn_reg;
    assign forward_speed = speed_reg;

endmodule

`default_nettype wire

### hdl/laser_scan_braitenberg_steer.sv
// ----------------------------------------------------------------------------
// laser_scan_braitenberg_steer
// obstacle avoidance steering from a streamed laser scan
//
// channel  | direction | contents
// s_axis   | in        | tdata[15:0] range_mm
// m_axis   | out       | tdata[31:0] turn_rate, tdata[47:32] forward_speed
// cfg      | in        | cfg_addr 0 angle_coef, 1 robot_speed, 2 beam_count,
//          |           | 3 angle_step
//
// one beam per cycle for every beam but the last of a scan
// last beam: the next beam is taken only after the multiply states MUL1 and MUL2,
// the 34-step restoring divider and the result load
// the result load waits while the previous result is not yet taken
// reset is asynchronous; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module laser_scan_braitenberg_steer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [15:0]                   s_tdata,   // range_mm
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [47:0]                   m_tdata,   // turn_rate, forward_speed
    input  wire logic                          cfg_we,
    input  wire logic [lsbs_pkg::CfgAddrW-1:0] cfg_addr,
    input  wire logic [lsbs_pkg::CfgW-1:0]     cfg_wdata
);

    lsbs_pkg::lsbs_cmd_t               cmd;
    lsbs_pkg::lsbs_stat_t              stat;
    logic [lsbs_pkg::TurnW-1:0]        turn_rate;
    logic [lsbs_pkg::SpeedW-1:0]       forward_speed;

    lsbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lsbs_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .range_mm      (s_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .turn_rate     (turn_rate),
        .forward_speed (forward_speed)
    );

    assign m_tdata = {forward_speed, turn_rate};

endmodule

`default_nettype wire

### hdl/lsbs_chk.sv
// ----------------------------------------------------------------------------
// lsbs_chk
// port-level checks for the steering block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lsbs_chk (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata
);

    // stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // a taken result leaves the output empty or is replaced by a fresh one
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid || s_tready)
        else $error("result repeated without a new computation");

    // a fresh result means the input side is open again
    a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("input blocked after result load");

endmodule

bind laser_scan_braitenberg_steer lsbs_chk u_lsbs_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
